@@ src/mshs_pkg.sv @@
// ----------------------------------------------------------------------------
// mshs_pkg
// Shared types for the merged sorted head select block: the input item and
// result payload structs, and the fixed field widths.
// ----------------------------------------------------------------------------
package mshs_pkg;

  localparam int WORD_W = 64;
  localparam int PRIO_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  typedef struct packed {
    logic  has_element;
    logic  elem_is_null;
    word_t elem_value;
    word_t order_key;
    word_t second_key;
    prio_t segment_priority;
    logic  segment_last;
    logic  row_last;
  } item_t;

  typedef struct packed {
    word_t result_value;
    logic  result_null;
  } result_t;

endpackage

@@ src/mshs_compare.sv @@
// ----------------------------------------------------------------------------
// mshs_compare
// Decides whether a segment head beats the current row winner: lower order
// key, then lower secondary key when enabled and different, then strictly
// higher segment priority. Earlier segment keeps exact ties.
// ----------------------------------------------------------------------------
module mshs_compare #(
  parameter int KEY_WIDTH = 64
) (
  input  logic                        secondary_enable,
  input  logic                        best_found,
  input  logic signed [KEY_WIDTH-1:0] cand_order,
  input  logic signed [KEY_WIDTH-1:0] cand_second,
  input  mshs_pkg::prio_t             cand_priority,
  input  logic signed [KEY_WIDTH-1:0] best_order,
  input  logic signed [KEY_WIDTH-1:0] best_second,
  input  mshs_pkg::prio_t             best_priority,
  output logic                        take
);

  logic order_ne;
  logic order_lt;
  logic second_ne;
  logic second_lt;
  logic prio_gt;

  // Evaluate all three key compares in parallel
  assign order_ne  = (cand_order != best_order);
  assign order_lt  = (cand_order < best_order);
  assign second_ne = (cand_second != best_second);
  assign second_lt = (cand_second < best_second);
  assign prio_gt   = (cand_priority > best_priority);

  // Select by precedence
  always_comb begin
    if (!best_found) begin
      take = 1'b1;
    end else if (order_ne) begin
      take = order_lt;
    end else if (secondary_enable && second_ne) begin
      take = second_lt;
    end else begin
      take = prio_gt;
    end
  end

endmodule

@@ src/merged_sorted_head_select_core.sv @@
// ----------------------------------------------------------------------------
// merged_sorted_head_select_core
// Picks the element a merge of a row's sorted segments would yield first.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) carries one element or end
//   marker per transfer; segment_last and row_last flag the boundaries. Only
//   the first non-null element of each segment competes against the row's
//   running winner.
//   result channel (result_valid / result_stall / result) carries one result
//   per row, produced by the transfer that has row_last set.
//   cfg_wr_en / cfg_wr_data write secondary_enable; write only while idle.
// Timing:
//   One item per cycle, sustained while item_stall is low. The compare against the
//   winner register is combinational and the winner update is registered; the result
//   appears in the output register in the cycle after the row_last transfer.
//   When the receiver stalls, the result register holds and item_stall rises
//   until the result is taken; a taken result can be replaced in the same
//   cycle, so rows follow back to back.
// Reset:
//   rst (synchronous) clears the winner valid flag, the segment head flag, the
//   output valid and secondary_enable.
// ----------------------------------------------------------------------------
module merged_sorted_head_select_core #(
  parameter int VALUE_WIDTH = 64,
  parameter int KEY_WIDTH   = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  mshs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mshs_pkg::result_t result
);

  // Configuration and control state
  logic secondary_enable;
  logic best_found;
  logic head_taken;

  // Winner payload, stored at parameter widths
  logic signed [KEY_WIDTH-1:0]   best_order;
  logic signed [KEY_WIDTH-1:0]   best_second;
  mshs_pkg::prio_t               best_priority;
  logic signed [VALUE_WIDTH-1:0] best_value;

  logic signed [KEY_WIDTH-1:0]   cand_order;
  logic signed [KEY_WIDTH-1:0]   cand_second;
  logic signed [VALUE_WIDTH-1:0] cand_value;

  logic                          accept;
  logic                          compete;
  logic                          take;
  logic                          win_found;
  logic signed [VALUE_WIDTH-1:0] win_value;
  mshs_pkg::result_t             result_next;

  // Backpressure only while a result is held
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // Narrow keys and value to the configured widths
  assign cand_order  = item.order_key[KEY_WIDTH-1:0];
  assign cand_second = item.second_key[KEY_WIDTH-1:0];
  assign cand_value  = item.elem_value[VALUE_WIDTH-1:0];

  assign compete = accept && item.has_element && !item.elem_is_null && !head_taken;

  mshs_compare #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_compare (
    .secondary_enable (secondary_enable),
    .best_found       (best_found),
    .cand_order       (cand_order),
    .cand_second      (cand_second),
    .cand_priority    (item.segment_priority),
    .best_order       (best_order),
    .best_second      (best_second),
    .best_priority    (best_priority),
    .take             (take)
  );

  // Winner including this item, used for the row result
  assign win_found = best_found || (compete && take);
  assign win_value = (compete && take) ? cand_value : best_value;

  always_comb begin
    result_next.result_null  = !win_found;
    result_next.result_value = win_found ? mshs_pkg::word_t'(win_value) : '0;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      secondary_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      secondary_enable <= cfg_wr_data;
    end
  end

  // Control: winner valid and segment head flag
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      head_taken <= 1'b0;
    end else if (accept) begin
      if (item.row_last) begin
        best_found <= 1'b0;
      end else begin
        best_found <= win_found;
      end
      if (item.segment_last || item.row_last) begin
        head_taken <= 1'b0;
      end else if (compete) begin
        head_taken <= 1'b1;
      end
    end
  end

  // Winner payload: load when the head wins
  always_ff @(posedge clk) begin
    if (compete && take) begin
      best_order    <= cand_order;
      best_second   <= cand_second;
      best_priority <= item.segment_priority;
      best_value    <= cand_value;
    end
  end

  // Output register: hold while stalled, refill on row end
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && item.row_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.row_last) begin
      result <= result_next;
    end
  end

endmodule

@@ src/mshs_checker.sv @@
// ----------------------------------------------------------------------------
// mshs_checker
// Port-level checks for merged_sorted_head_select_core: result timing against
// row ends, held results under stall, and null results carrying zero.
// ----------------------------------------------------------------------------
module mshs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input mshs_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input mshs_pkg::result_t result
);

  logic row_end;

  assign row_end = item_valid && !item_stall && item.row_last;

  // Hold a stalled result
  a_result_hold : assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Row end transfer yields a result next cycle
  a_row_result : assert property (@(posedge clk) disable iff (rst)
    row_end |=> result_valid)
    else $error("row end without result");

  // No result appears without a row end
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    !row_end && !(result_valid && result_stall) |=> !result_valid)
    else $error("result without row end");

  // Null result carries zero value
  a_null_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_null |-> result.result_value == '0)
    else $error("null result with nonzero value");

endmodule

bind merged_sorted_head_select_core mshs_checker u_mshs_checker (.*);
